// ===== rtl/i2cmon_pkg.sv =====
`default_nettype none

package i2cmon_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RegIdxW  = 3;

  // register index codes
  localparam logic [RegIdxW-1:0] RegStartSym   = 3'd0;
  localparam logic [RegIdxW-1:0] RegStopSym    = 3'd1;
  localparam logic [RegIdxW-1:0] RegAckSym     = 3'd2;
  localparam logic [RegIdxW-1:0] RegNackSym    = 3'd3;
  localparam logic [RegIdxW-1:0] RegLineEndSym = 3'd4;

  localparam logic [CharW-1:0] StartSymRst   = 8'd83;
  localparam logic [CharW-1:0] StopSymRst    = 8'd80;
  localparam logic [CharW-1:0] AckSymRst     = 8'd65;
  localparam logic [CharW-1:0] NackSymRst    = 8'd78;
  localparam logic [CharW-1:0] LineEndSymRst = 8'd10;

  localparam logic [CharW-1:0] AsciiZero     = 8'd48;
  // distance from '9'+1 to 'A'
  localparam logic [CharW-1:0] HexAlphaGap   = 8'd7;

  typedef struct packed {
    logic [CharW-1:0] start_sym;
    logic [CharW-1:0] stop_sym;
    logic [CharW-1:0] ack_sym;
    logic [CharW-1:0] nack_sym;
    logic [CharW-1:0] line_end_sym;
  } cfg_t;

  // one queue entry: the characters caused by one sample
  typedef struct packed {
    logic [CharW-1:0] char0;
    logic [CharW-1:0] char1;
    logic             two;
  } qent_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } qstat_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    c = AsciiZero + {4'd0, nib};
    if (nib > 4'd9) begin
      c = c + HexAlphaGap;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cmon_front.sv =====
`default_nettype none

module i2cmon_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              scl_i,
  input  wire logic              sda_i,
  input  wire i2cmon_pkg::cfg_t  cfg_i,
  output logic                   push_o,
  output i2cmon_pkg::qent_t      push_ent_o
);
  import i2cmon_pkg::*;

  logic       prev_scl_q, prev_scl_d;
  logic       prev_sda_q, prev_sda_d;
  logic       in_xfer_q, in_xfer_d;
  logic       exp_ack_q, exp_ack_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;

  logic       held_high, is_start, is_stop, clk_rise;
  logic [3:0] cnt_inc;
  logic [7:0] shift_nxt;

  assign held_high = prev_scl_q & scl_i;
  assign is_start  = held_high & prev_sda_q & ~sda_i;
  assign is_stop   = held_high & ~prev_sda_q & sda_i;
  assign clk_rise  = ~prev_scl_q & scl_i;
  assign cnt_inc   = bit_cnt_q + 4'd1;
  assign shift_nxt = {shift_q[6:0], sda_i};

  always_comb begin
    prev_scl_d = prev_scl_q;
    prev_sda_d = prev_sda_q;
    in_xfer_d  = in_xfer_q;
    exp_ack_d  = exp_ack_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    push_o     = 1'b0;
    push_ent_o = '0;
    if (accept_i) begin
      prev_scl_d = scl_i;
      prev_sda_d = sda_i;
      if (is_start) begin
        push_o           = 1'b1;
        push_ent_o.char0 = cfg_i.start_sym;
        in_xfer_d        = 1'b1;
        exp_ack_d        = 1'b0;
        bit_cnt_d        = '0;
        shift_d          = '0;
      end else if (is_stop) begin
        push_o           = 1'b1;
        push_ent_o.char0 = cfg_i.stop_sym;
        push_ent_o.char1 = cfg_i.line_end_sym;
        push_ent_o.two   = 1'b1;
        in_xfer_d        = 1'b0;
        exp_ack_d        = 1'b0;
        bit_cnt_d        = '0;
        shift_d          = '0;
      end else if (clk_rise && in_xfer_q) begin
        if (exp_ack_q) begin
          push_o           = 1'b1;
          push_ent_o.char0 = sda_i ? cfg_i.nack_sym : cfg_i.ack_sym;
          exp_ack_d        = 1'b0;
          bit_cnt_d        = '0;
          shift_d          = '0;
        end else begin
          shift_d   = shift_nxt;
          bit_cnt_d = cnt_inc;
          if (cnt_inc >= 4'd8) begin
            push_o           = 1'b1;
            push_ent_o.char0 = hex_char(shift_nxt[7:4]);
            push_ent_o.char1 = hex_char(shift_nxt[3:0]);
            push_ent_o.two   = 1'b1;
            exp_ack_d        = 1'b1;
            bit_cnt_d        = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_scl_q <= 1'b1;
      prev_sda_q <= 1'b1;
      in_xfer_q  <= 1'b0;
      exp_ack_q  <= 1'b0;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
    end else begin
      prev_scl_q <= prev_scl_d;
      prev_sda_q <= prev_sda_d;
      in_xfer_q  <= in_xfer_d;
      exp_ack_q  <= exp_ack_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cmon_queue.sv =====
`default_nettype none

module i2cmon_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire i2cmon_pkg::qent_t  push_ent_i,
  input  wire logic               pop_i,
  output i2cmon_pkg::qent_t       head_o,
  output i2cmon_pkg::qstat_t      stat_o
);
  import i2cmon_pkg::*;

  qent_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cmon_back.sv =====
`default_nettype none

module i2cmon_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire i2cmon_pkg::qent_t           head_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [i2cmon_pkg::CharW-1:0]     m_axis_tdata, // [7:0] trace_char
  output logic                             m_axis_tlast
);
  import i2cmon_pkg::*;

  logic  have_q, have_d;
  logic  phase_q, phase_d;
  qent_t ent_q, ent_d;
  logic  xfer, done;

  assign m_axis_tvalid = have_q;
  assign m_axis_tdata  = phase_q ? ent_q.char1 : ent_q.char0;
  assign m_axis_tlast  = phase_q | ~ent_q.two;

  assign xfer  = have_q & m_axis_tready;
  assign done  = xfer & m_axis_tlast;
  assign pop_o = ~q_empty_i & (~have_q | done);

  always_comb begin
    have_d  = have_q;
    phase_d = phase_q;
    ent_d   = ent_q;
    if (pop_o) begin
      // load the next entry straight behind the one just finished
      have_d  = 1'b1;
      phase_d = 1'b0;
      ent_d   = head_i;
    end else if (done) begin
      have_d  = 1'b0;
      phase_d = 1'b0;
    end else if (xfer) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      have_q  <= have_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_bus_monitor_ascii_trace_top.sv =====
// A sample's characters pass from the classifier through the queue and the
//   serialiser's register; a second character follows once the first is taken.
// Throughput: one sample per cycle unless the queue is full; characters leave at
//   one per cycle while ready; a 4-entry queue absorbs two-character bursts.
// Reset (rst_ni, asynchronous, active low): bus levels taken as high, idle, queue
//   empty, symbol registers at their default codes.
`default_nettype none

module i2c_bus_monitor_ascii_trace_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata, // [0] scl, [1] sda
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [i2cmon_pkg::CharW-1:0]        m_axis_tdata, // [7:0] trace_char
  output logic                                m_axis_tlast,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [i2cmon_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import i2cmon_pkg::*;

  cfg_t             cfg_q;
  logic             cfg_wr;
  logic [RegIdxW-1:0] reg_idx;
  logic             accept;
  logic             push, pop;
  qent_t            push_ent, head;
  qstat_t           qstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    case (reg_idx)
      RegStartSym:   prdata = {24'd0, cfg_q.start_sym};
      RegStopSym:    prdata = {24'd0, cfg_q.stop_sym};
      RegAckSym:     prdata = {24'd0, cfg_q.ack_sym};
      RegNackSym:    prdata = {24'd0, cfg_q.nack_sym};
      RegLineEndSym: prdata = {24'd0, cfg_q.line_end_sym};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_sym    <= StartSymRst;
      cfg_q.stop_sym     <= StopSymRst;
      cfg_q.ack_sym      <= AckSymRst;
      cfg_q.nack_sym     <= NackSymRst;
      cfg_q.line_end_sym <= LineEndSymRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegStartSym:   cfg_q.start_sym    <= pwdata[CharW-1:0];
        RegStopSym:    cfg_q.stop_sym     <= pwdata[CharW-1:0];
        RegAckSym:     cfg_q.ack_sym      <= pwdata[CharW-1:0];
        RegNackSym:    cfg_q.nack_sym     <= pwdata[CharW-1:0];
        RegLineEndSym: cfg_q.line_end_sym <= pwdata[CharW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~qstat.full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  i2cmon_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .scl_i      (s_axis_tdata[0]),
    .sda_i      (s_axis_tdata[1]),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .push_ent_o (push_ent)
  );

  i2cmon_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  i2cmon_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (qstat.empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into a full queue");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second character of a pair missing");

endmodule

`default_nettype wire

// ===== dv/i2c_bus_monitor_ascii_trace_top_tb.sv =====
`timescale 1ns / 1ps

module i2c_bus_monitor_ascii_trace_top_tb;
  import i2cmon_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseSamples = 80;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } trace_char_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // [0] scl, [1] sda
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [CharW-1:0]  m_axis_tdata;        // [7:0] trace_char
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  i2c_bus_monitor_ascii_trace_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // bus samples waiting to be sent, bit 0 scl and bit 1 sda
  logic [1:0]        bus_samples[$];
  trace_char_t       trace_due[$];
  trace_char_t       want_char;
  logic              sample_taken = 1'b0;
  int unsigned       samples_in = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches = 0;
  logic              calm;

  // shadow of the symbol registers and of the bus tracker
  logic [CharW-1:0]  sym_cfg [5];
  logic              trk_scl;
  logic              trk_sda;
  logic              trk_busy;
  logic              trk_ack_due;
  logic [3:0]        trk_bits;
  logic [7:0]        trk_shift;

  assign calm = (samples_in >= 300) && (samples_in < 420);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got 0x%02h, want 0x%02h (at %0t)", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    // ASCII '0' for digits, 'A' minus ten for letters
    return (nib < 4'd10) ? 8'd48 + nib : 8'd55 + nib;
  endfunction

  task automatic emit_char(input logic [7:0] c, input logic last);
    trace_due.push_back('{ch: c, last: last});
  endtask

  task automatic predict_trace(input logic scl, input logic sda);
    logic held;
    logic rise;
    held = trk_scl && scl;
    rise = !trk_scl && scl;
    if (held && trk_sda && !sda) begin
      emit_char(sym_cfg[RegStartSym], 1'b1);
      trk_busy = 1'b1;
      trk_ack_due = 1'b0;
      trk_bits = '0;
      trk_shift = '0;
    end else if (held && !trk_sda && sda) begin
      emit_char(sym_cfg[RegStopSym], 1'b0);
      emit_char(sym_cfg[RegLineEndSym], 1'b1);
      trk_busy = 1'b0;
      trk_ack_due = 1'b0;
      trk_bits = '0;
      trk_shift = '0;
    end else if (rise && trk_busy) begin
      if (trk_ack_due) begin
        emit_char(sda ? sym_cfg[RegNackSym] : sym_cfg[RegAckSym], 1'b1);
        trk_ack_due = 1'b0;
        trk_bits = '0;
        trk_shift = '0;
      end else begin
        trk_shift = {trk_shift[6:0], sda};
        trk_bits = trk_bits + 4'd1;
        if (trk_bits >= 4'd8) begin
          emit_char(hex_digit(trk_shift[7:4]), 1'b0);
          emit_char(hex_digit(trk_shift[3:0]), 1'b1);
          trk_ack_due = 1'b1;
          trk_bits = '0;
        end
      end
    end
    trk_scl = scl;
    trk_sda = sda;
  endtask

  // sample driver: one transfer per bus sample, gaps at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(99) >= 30);
      if (!s_axis_tvalid || sample_taken) begin
        if (bus_samples.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          s_axis_tdata <= {6'd0, bus_samples.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check characters, predict from accepted samples, watch for a hang
  always @(posedge clk_i) begin
    sample_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (trace_due.size() == 0) begin
          report_mismatch("unexpected character", m_axis_tdata, 8'd0);
        end else begin
          want_char = trace_due.pop_front();
          if (m_axis_tdata !== want_char.ch)
            report_mismatch("trace_char", m_axis_tdata, want_char.ch);
          if (m_axis_tlast !== want_char.last)
            report_mismatch("last_of_run", {7'd0, m_axis_tlast}, {7'd0, want_char.last});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_trace(s_axis_tdata[0], s_axis_tdata[1]);
        samples_in <= samples_in + 1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx <= RegLineEndSym)
      sym_cfg[idx] = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_symbols(input logic [7:0] s, input logic [7:0] p, input logic [7:0] a,
                             input logic [7:0] n, input logic [7:0] l);
    apb_write(RegStartSym, s);
    apb_write(RegStopSym, p);
    apb_write(RegAckSym, a);
    apb_write(RegNackSym, n);
    apb_write(RegLineEndSym, l);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (bus_samples.size() > 0 || s_axis_tvalid || trace_due.size() > 0);
    // samples that cause nothing may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_level(input logic scl, input logic sda);
    bus_samples.push_back({sda, scl});
  endtask

  // start and repeated start look the same on the wire
  task automatic push_start();
    push_level(1'b0, 1'b1);
    push_level(1'b1, 1'b1);
    push_level(1'b1, 1'b0);
  endtask

  task automatic push_stop();
    push_level(1'b0, 1'b0);
    push_level(1'b1, 1'b0);
    push_level(1'b1, 1'b1);
  endtask

  task automatic push_bit(input logic b);
    repeat ($urandom_range(2, 1)) push_level(1'b0, b);
    repeat ($urandom_range(2, 1)) push_level(1'b1, b);
    push_level(1'b0, b);
  endtask

  // send the top bits_sent bits of a byte; the acknowledge only after all eight
  task automatic push_byte(input logic [7:0] value, input logic ack_level,
                           input int bits_sent);
    for (int k = 7; k >= 8 - bits_sent; k--)
      push_bit(value[k]);
    if (bits_sent == 8)
      push_bit(ack_level);
  endtask

  task automatic add_frame();
    int nbytes;
    int roll;
    logic [7:0] value;
    if ($urandom_range(99) < 12) begin
      // line noise
      repeat ($urandom_range(12, 4)) push_level(1'($urandom_range(1)), 1'($urandom_range(1)));
      return;
    end
    push_start();
    nbytes = $urandom_range(3, 1);
    for (int i = 0; i < nbytes; i++) begin
      roll = $urandom_range(99);
      value = (roll < 15) ? 8'h00 : (roll < 30) ? 8'hFF : 8'($urandom_range(255));
      push_byte(value, 1'($urandom_range(1)),
                ($urandom_range(99) < 8) ? int'($urandom_range(7, 1)) : 8);
      if ($urandom_range(99) < 15)
        push_start();
    end
    if ($urandom_range(99) < 90)
      push_stop();
  endtask

  task automatic run_phase();
    int goal;
    @(posedge clk_i);
    goal = bus_samples.size() + PhaseSamples;
    while (bus_samples.size() < goal)
      add_frame();
    wait_drained();
  endtask

  initial begin
    sym_cfg[RegStartSym] = StartSymRst;
    sym_cfg[RegStopSym] = StopSymRst;
    sym_cfg[RegAckSym] = AckSymRst;
    sym_cfg[RegNackSym] = NackSymRst;
    sym_cfg[RegLineEndSym] = LineEndSymRst;
    trk_scl = 1'b1;
    trk_sda = 1'b1;
    trk_busy = 1'b0;
    trk_ack_due = 1'b0;
    trk_bits = '0;
    trk_shift = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stop on an idle bus, with a clock pulse in between that must be ignored
    push_level(1'b0, 1'b0);
    push_level(1'b1, 1'b0);
    push_level(1'b1, 1'b1);
    // start, then a bit clocked on a sample where both lines move
    push_level(1'b1, 1'b0);
    push_level(1'b0, 1'b1);
    push_level(1'b1, 1'b0);
    push_level(1'b0, 1'b1);
    push_level(1'b1, 1'b1);
    // repeated start drops the partial byte
    push_level(1'b1, 1'b0);
    // all ones, nack, then a stray bit before the stop
    repeat (9) begin
      push_level(1'b0, 1'b1);
      push_level(1'b1, 1'b1);
    end
    push_stop();
    wait_drained();
    run_phase();

    set_symbols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_phase();
    set_symbols(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_phase();
    set_symbols(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    // an index past the last register must change nothing
    apb_write(RegLineEndSym + 3'd1 + 3'($urandom_range(2)), 8'($urandom_range(255)));
    run_phase();
    set_symbols(StartSymRst, StopSymRst, AckSymRst, NackSymRst, LineEndSymRst);
    run_phase();

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
